// File: design/mcrt_pkg.sv
// ----------------------------------------------------------------------------
// mcrt_pkg
// Shared constants, action codes and controller command type for the
// repeat timer table.
// ----------------------------------------------------------------------------
package mcrt_pkg;

   localparam int NUM_TIMERS = 8;
   localparam int TIDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   localparam int ACT_W   = 4;
   localparam int INDEX_W = 8;
   localparam int TICK_W  = 16;
   localparam int REP_W   = 8;
   localparam int MASK_W  = 8;

   typedef enum logic [ACT_W-1:0] {
      ACT_TICK           = 4'd0,
      ACT_CREATE         = 4'd1,
      ACT_START          = 4'd2,
      ACT_STOP           = 4'd3,
      ACT_CLEAR          = 4'd4,
      ACT_SET_TICKS      = 4'd5,
      ACT_SET_REPEATS    = 4'd6,
      ACT_RELOAD_TICKS   = 4'd7,
      ACT_RELOAD_REPEATS = 4'd8,
      ACT_READ           = 4'd9
   } action_type;

   typedef struct packed {
      logic              capture;
      logic              do_cmd;
      logic              do_step;
      logic              last;
      logic [TIDX_W-1:0] step_idx;
   } mcrt_cmd_type;

endpackage

// File: design/mcrt_ctrl.sv
// ----------------------------------------------------------------------------
// mcrt_ctrl
// Sequencer: accepts a request, runs a single command state or a sweep over
// the timer table for a tick, and strobes the response.
// ----------------------------------------------------------------------------
module mcrt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mcrt_pkg::ACT_W-1:0]   req_action,
   output logic                         busy,
   output logic                         rsp_valid,
   output mcrt_pkg::mcrt_cmd_type       cmd
);
   import mcrt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_SWEEP
   } state_type;

   localparam logic [TIDX_W-1:0] LAST_IDX = TIDX_W'(NUM_TIMERS - 1);

   state_type         state_ff;
   logic [TIDX_W-1:0] cnt_ff;
   logic              rsp_valid_ff;
   logic              accept;
   logic              last_step;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign last_step = (cnt_ff == LAST_IDX);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.capture  = accept;
      cmd.do_cmd   = (state_ff == ST_CMD);
      cmd.do_step  = (state_ff == ST_SWEEP);
      cmd.last     = last_step;
      cmd.step_idx = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  if (req_action == ACT_TICK) begin
                     state_ff <= ST_SWEEP;
                  end else begin
                     state_ff <= ST_CMD;
                  end
               end
            end
            ST_CMD: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            ST_SWEEP: begin
               if (last_step) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  cnt_ff       <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: design/mcrt_dp.sv
// ----------------------------------------------------------------------------
// mcrt_dp
// Timer table datapath: request holding registers, per-timer state, one
// entry update per cycle and the response registers.
// ----------------------------------------------------------------------------
module mcrt_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  mcrt_pkg::mcrt_cmd_type          cmd,
   input  logic [mcrt_pkg::ACT_W-1:0]      req_action,
   input  logic [mcrt_pkg::INDEX_W-1:0]    req_timer_index,
   input  logic [mcrt_pkg::TICK_W-1:0]     req_tick_count,
   input  logic [mcrt_pkg::REP_W-1:0]      req_repeat_count,
   input  logic                            req_enable_now,
   output logic [mcrt_pkg::MASK_W-1:0]     rsp_expired_mask,
   output logic [mcrt_pkg::TICK_W-1:0]     rsp_remaining_ticks,
   output logic                            rsp_index_bad
);
   import mcrt_pkg::*;

   // request holding registers
   logic [ACT_W-1:0]   act_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [TICK_W-1:0]  ticks_ff;
   logic [REP_W-1:0]   reps_ff;
   logic               en_ff;

   // timer table
   logic [TICK_W-1:0] reload_ff  [NUM_TIMERS];
   logic [TICK_W-1:0] current_ff [NUM_TIMERS];
   logic [REP_W-1:0]  left_ff    [NUM_TIMERS];
   logic [REP_W-1:0]  initial_ff [NUM_TIMERS];
   logic              run_ff     [NUM_TIMERS];

   logic [MASK_W-1:0] mask_ff;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic [TICK_W-1:0] rsp_remain_ff;
   logic              rsp_bad_ff;

   logic [TIDX_W-1:0] sel;
   logic              idx_bad;
   logic              act_used;
   logic [TICK_W-1:0] cur_rd;
   logic [TICK_W-1:0] rel_rd;
   logic [REP_W-1:0]  left_rd;
   logic [REP_W-1:0]  init_rd;
   logic              run_rd;
   logic [TICK_W-1:0] cur_dec;

   logic              wr_en;
   logic [TICK_W-1:0] reload_in;
   logic [TICK_W-1:0] current_in;
   logic [REP_W-1:0]  left_in;
   logic [REP_W-1:0]  initial_in;
   logic              run_in;
   logic              expire;
   logic [MASK_W-1:0] step_bit;
   logic [MASK_W-1:0] mask_in;

   assign idx_bad  = (idx_ff >= INDEX_W'(NUM_TIMERS));
   assign act_used = (act_ff >= ACT_CREATE) && (act_ff <= ACT_READ);
   assign sel      = cmd.do_step ? cmd.step_idx : idx_ff[TIDX_W-1:0];

   always_comb begin
      cur_rd  = '0;
      rel_rd  = '0;
      left_rd = '0;
      init_rd = '0;
      run_rd  = 1'b0;
      for (int j = 0; j < NUM_TIMERS; j++) begin
         if (32'(sel) == j) begin
            cur_rd  = current_ff[j];
            rel_rd  = reload_ff[j];
            left_rd = left_ff[j];
            init_rd = initial_ff[j];
            run_rd  = run_ff[j];
         end
      end
   end

   assign cur_dec = cur_rd - 1'b1;

   // entry update for either a command or one sweep step
   always_comb begin
      wr_en      = 1'b0;
      reload_in  = rel_rd;
      current_in = cur_rd;
      left_in    = left_rd;
      initial_in = init_rd;
      run_in     = run_rd;
      expire     = 1'b0;
      if (cmd.do_step) begin
         if (run_rd && (cur_rd != '0)) begin
            wr_en      = 1'b1;
            current_in = cur_dec;
            if (cur_dec == '0) begin
               expire = 1'b1;
               if (left_rd == '0) begin
                  current_in = rel_rd;
               end else if (left_rd == REP_W'(1)) begin
                  run_in = 1'b0;
               end else begin
                  left_in    = left_rd - 1'b1;
                  current_in = rel_rd;
               end
            end
         end
      end else if (cmd.do_cmd && !idx_bad) begin
         wr_en = 1'b1;
         case (act_ff)
            ACT_CREATE: begin
               reload_in  = ticks_ff;
               current_in = ticks_ff;
               left_in    = reps_ff;
               initial_in = reps_ff;
               run_in     = en_ff;
            end
            ACT_START: begin
               run_in = 1'b1;
            end
            ACT_STOP: begin
               run_in = 1'b0;
            end
            ACT_CLEAR: begin
               reload_in  = '0;
               current_in = '0;
               left_in    = '0;
               initial_in = '0;
               run_in     = 1'b0;
            end
            ACT_SET_TICKS: begin
               reload_in  = ticks_ff;
               current_in = ticks_ff;
            end
            ACT_SET_REPEATS: begin
               left_in    = reps_ff;
               initial_in = reps_ff;
            end
            ACT_RELOAD_TICKS: begin
               current_in = rel_rd;
            end
            ACT_RELOAD_REPEATS: begin
               left_in = init_rd;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   // timers past the eighth have no mask bit
   always_comb begin
      step_bit = '0;
      for (int j = 0; j < MASK_W; j++) begin
         if ((j < NUM_TIMERS) && (32'(cmd.step_idx) == j)) begin
            step_bit[j] = expire;
         end
      end
   end

   assign mask_in = mask_ff | step_bit;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         idx_ff   <= req_timer_index;
         ticks_ff <= req_tick_count;
         reps_ff  <= req_repeat_count;
         en_ff    <= req_enable_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_TIMERS; j++) begin
            reload_ff[j]  <= '0;
            current_ff[j] <= '0;
            left_ff[j]    <= '0;
            initial_ff[j] <= '0;
            run_ff[j]     <= 1'b0;
         end
         mask_ff <= '0;
      end else begin
         if (wr_en) begin
            reload_ff[sel]  <= reload_in;
            current_ff[sel] <= current_in;
            left_ff[sel]    <= left_in;
            initial_ff[sel] <= initial_in;
            run_ff[sel]     <= run_in;
         end
         if (cmd.capture) begin
            mask_ff <= '0;
         end else if (cmd.do_step) begin
            mask_ff <= mask_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_cmd) begin
         rsp_mask_ff   <= '0;
         rsp_bad_ff    <= act_used && idx_bad;
         rsp_remain_ff <= (act_ff == ACT_READ && !idx_bad) ? cur_rd : '0;
      end else if (cmd.do_step && cmd.last) begin
         rsp_mask_ff   <= mask_in;
         rsp_bad_ff    <= 1'b0;
         rsp_remain_ff <= '0;
      end
   end

   assign rsp_expired_mask    = rsp_mask_ff;
   assign rsp_remaining_ticks = rsp_remain_ff;
   assign rsp_index_bad       = rsp_bad_ff;

endmodule

// File: design/multi_channel_repeat_timer_top.sv
// ----------------------------------------------------------------------------
// multi_channel_repeat_timer_top
// Table of countdown timers with repeat counts; commands edit or read one timer,
// a tick request sweeps the whole table and reports expiries as a mask.
//
//   channel   handshake             payload
//   request   start & !busy         req_action, req_timer_index,
//                                   req_tick_count, req_repeat_count,
//                                   req_enable_now
//   response  rsp_valid (1 cycle)   rsp_expired_mask, rsp_remaining_ticks,
//                                   rsp_index_bad
//
// a command request passes through ST_CMD from accept to response strobe, a
// tick through ST_SWEEP: the table is swept one timer per cycle through a
// single update port. busy is low again in the cycle the strobe shows.
// synchronous reset clears every timer to zero and not running.
// the response cannot be held off; it is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module multi_channel_repeat_timer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [mcrt_pkg::ACT_W-1:0]      req_action,
   input  logic [mcrt_pkg::INDEX_W-1:0]    req_timer_index,
   input  logic [mcrt_pkg::TICK_W-1:0]     req_tick_count,
   input  logic [mcrt_pkg::REP_W-1:0]      req_repeat_count,
   input  logic                            req_enable_now,
   output logic                            rsp_valid,
   output logic [mcrt_pkg::MASK_W-1:0]     rsp_expired_mask,
   output logic [mcrt_pkg::TICK_W-1:0]     rsp_remaining_ticks,
   output logic                            rsp_index_bad
);
   import mcrt_pkg::*;

   mcrt_cmd_type cmd;

   mcrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   mcrt_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_action          (req_action),
      .req_timer_index     (req_timer_index),
      .req_tick_count      (req_tick_count),
      .req_repeat_count    (req_repeat_count),
      .req_enable_now      (req_enable_now),
      .rsp_expired_mask    (rsp_expired_mask),
      .rsp_remaining_ticks (rsp_remaining_ticks),
      .rsp_index_bad       (rsp_index_bad)
   );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the repeat timer table: every accepted request
// updates a model of the table and queues the expected response, and each
// response strobe is checked field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module tb_top;
   import mcrt_pkg::*;

   localparam int                 REQ_TOTAL     = 2000;
   localparam int                 CALM_TAIL     = 300;
   localparam int                 REPORT_LIMIT  = 10;
   localparam logic [ACT_W-1:0]   ACT_UNUSED_LO = ACT_W'(ACT_READ + 1);
   localparam logic [ACT_W-1:0]   ACT_UNUSED_HI = '1;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [ACT_W-1:0]     req_action;
   logic [INDEX_W-1:0]   req_timer_index;
   logic [TICK_W-1:0]    req_tick_count;
   logic [REP_W-1:0]     req_repeat_count;
   logic                 req_enable_now;
   logic                 rsp_valid;
   logic [MASK_W-1:0]    rsp_expired_mask;
   logic [TICK_W-1:0]    rsp_remaining_ticks;
   logic                 rsp_index_bad;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [TICK_W-1:0] remain;
      logic              bad;
   } timer_response_type;

   class timer_scoreboard;
      logic [TICK_W-1:0]  reload_val [NUM_TIMERS];
      logic [TICK_W-1:0]  count_val  [NUM_TIMERS];
      logic [REP_W-1:0]   reps_left  [NUM_TIMERS];
      logic [REP_W-1:0]   reps_init  [NUM_TIMERS];
      bit                 running    [NUM_TIMERS];
      timer_response_type expected_q [$];
      int                 mismatches;

      function new();
         mismatches = 0;
         for (int k = 0; k < NUM_TIMERS; k++) begin
            reload_val[k] = '0;
            count_val[k]  = '0;
            reps_left[k]  = '0;
            reps_init[k]  = '0;
            running[k]    = 1'b0;
         end
      endfunction

      function logic [MASK_W-1:0] sweep_ticks();
         logic [MASK_W-1:0] mask;
         mask = '0;
         for (int k = 0; k < NUM_TIMERS; k++) begin
            if (running[k] && count_val[k] != 0) begin
               count_val[k] = count_val[k] - 1'b1;
               if (count_val[k] == 0) begin
                  if (reps_left[k] == 0) begin
                     count_val[k] = reload_val[k];
                  end else if (reps_left[k] == 1) begin
                     running[k] = 1'b0;
                  end else begin
                     reps_left[k] = reps_left[k] - 1'b1;
                     count_val[k] = reload_val[k];
                  end
                  if (k < MASK_W) mask[k] = 1'b1;
               end
            end
         end
         return mask;
      endfunction

      function void note_request(logic [ACT_W-1:0] act, logic [INDEX_W-1:0] idx,
                                 logic [TICK_W-1:0] ticks, logic [REP_W-1:0] reps,
                                 logic en);
         timer_response_type rsp;
         int                 k;
         rsp = '0;
         k   = int'(idx);
         if (act == ACT_TICK) begin
            rsp.mask = sweep_ticks();
         end else if (act <= ACT_READ) begin
            if (idx >= NUM_TIMERS) begin
               rsp.bad = 1'b1;
            end else begin
               case (act)
                  ACT_CREATE: begin
                     reload_val[k] = ticks;
                     count_val[k]  = ticks;
                     reps_left[k]  = reps;
                     reps_init[k]  = reps;
                     running[k]    = en;
                  end
                  ACT_START:  running[k] = 1'b1;
                  ACT_STOP:   running[k] = 1'b0;
                  ACT_CLEAR: begin
                     reload_val[k] = '0;
                     count_val[k]  = '0;
                     reps_left[k]  = '0;
                     reps_init[k]  = '0;
                     running[k]    = 1'b0;
                  end
                  ACT_SET_TICKS: begin
                     reload_val[k] = ticks;
                     count_val[k]  = ticks;
                  end
                  ACT_SET_REPEATS: begin
                     reps_left[k] = reps;
                     reps_init[k] = reps;
                  end
                  ACT_RELOAD_TICKS:   count_val[k] = reload_val[k];
                  ACT_RELOAD_REPEATS: reps_left[k] = reps_init[k];
                  default:            rsp.remain = count_val[k];
               endcase
            end
         end
         expected_q.push_back(rsp);
      endfunction

      function void check_response(logic [MASK_W-1:0] mask, logic [TICK_W-1:0] remain,
                                   logic bad);
         timer_response_type want;
         if (expected_q.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("unexpected response: mask=%h remain=%h bad=%b", mask, remain, bad);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (mask !== want.mask || remain !== want.remain || bad !== want.bad) begin
               if (mismatches < REPORT_LIMIT)
                  $display({"response mismatch: mask exp=%h got=%h ",
                            "remain exp=%h got=%h bad exp=%b got=%b"},
                           want.mask, mask, want.remain, remain, want.bad, bad);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   timer_scoreboard timer_sb = new();

   multi_channel_repeat_timer_top DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_timer_index     (req_timer_index),
      .req_tick_count      (req_tick_count),
      .req_repeat_count    (req_repeat_count),
      .req_enable_now      (req_enable_now),
      .rsp_valid           (rsp_valid),
      .rsp_expired_mask    (rsp_expired_mask),
      .rsp_remaining_ticks (rsp_remaining_ticks),
      .rsp_index_bad       (rsp_index_bad)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response is checked before a request accepted on the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            timer_sb.check_response(rsp_expired_mask, rsp_remaining_ticks, rsp_index_bad);
         if (start && !busy)
            timer_sb.note_request(req_action, req_timer_index, req_tick_count,
                                  req_repeat_count, req_enable_now);
      end
   end

   // called just after a falling edge; returns just after a falling edge, once the request has been accepted
   task automatic send_request(logic [ACT_W-1:0] act, logic [INDEX_W-1:0] idx,
                               logic [TICK_W-1:0] ticks, logic [REP_W-1:0] reps,
                               logic en);
      start            = 1'b1;
      req_action       = act;
      req_timer_index  = idx;
      req_tick_count   = ticks;
      req_repeat_count = reps;
      req_enable_now   = en;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // idle with junk on the payload ports
   task automatic idle_burst(int cycles);
      start            = 1'b0;
      req_action       = ACT_W'($urandom);
      req_timer_index  = INDEX_W'($urandom);
      req_tick_count   = TICK_W'($urandom);
      req_repeat_count = REP_W'($urandom);
      req_enable_now   = 1'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic [ACT_W-1:0] pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return ACT_TICK;
      if (r < 50) return ACT_CREATE;
      if (r < 58) return ACT_START;
      if (r < 63) return ACT_STOP;
      if (r < 66) return ACT_CLEAR;
      if (r < 72) return ACT_SET_TICKS;
      if (r < 78) return ACT_SET_REPEATS;
      if (r < 83) return ACT_RELOAD_TICKS;
      if (r < 88) return ACT_RELOAD_REPEATS;
      if (r < 98) return ACT_READ;
      return ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
   endfunction

   initial begin
      int               issued;
      logic [ACT_W-1:0] act;
      logic [INDEX_W-1:0] idx;
      logic [TICK_W-1:0]  ticks;
      logic [REP_W-1:0]   reps;

      reset            = 1'b1;
      start            = 1'b0;
      req_action       = '0;
      req_timer_index  = '0;
      req_tick_count   = '0;
      req_repeat_count = '0;
      req_enable_now   = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: reset state, expiry modes, every action, bad index, unused codes
      send_request(ACT_READ, 0, 16'h1234, 8'h56, 1'b1);
      send_request(ACT_CREATE, 0, 2, 1, 1'b1);            // stops on last repeat
      send_request(ACT_CREATE, 1, 1, 0, 1'b1);            // reloads forever
      send_request(ACT_CREATE, INDEX_W'(NUM_TIMERS - 1), '1, '1, 1'b1);
      send_request(ACT_CREATE, 2, 3, 2, 1'b0);
      send_request(ACT_CREATE, 3, 0, 0, 1'b1);            // running with count zero
      send_request(ACT_START, 2, 0, 0, 1'b0);
      send_request(ACT_TICK, '1, '1, '1, 1'b1);
      send_request(ACT_TICK, 0, 0, 0, 1'b0);
      send_request(ACT_READ, 0, 0, 0, 1'b0);
      idle_burst(2);
      send_request(ACT_TICK, 0, 0, 0, 1'b0);
      send_request(ACT_TICK, 0, 0, 0, 1'b0);
      send_request(ACT_STOP, 1, 0, 0, 1'b0);
      send_request(ACT_SET_TICKS, 1, 5, 0, 1'b0);
      send_request(ACT_SET_REPEATS, 1, 0, 3, 1'b0);
      send_request(ACT_RELOAD_TICKS, 0, 0, 0, 1'b0);
      send_request(ACT_RELOAD_REPEATS, 0, 0, 0, 1'b0);
      send_request(ACT_CLEAR, INDEX_W'(NUM_TIMERS - 1), 0, 0, 1'b0);
      send_request(ACT_READ, 2, 0, 0, 1'b0);
      send_request(ACT_READ, INDEX_W'(NUM_TIMERS), 0, 0, 1'b0);
      send_request(ACT_CREATE, '1, '1, '1, 1'b1);
      send_request(ACT_UNUSED_HI, '1, '1, '1, 1'b1);
      send_request(ACT_UNUSED_LO, 1, 1, 1, 1'b0);
      send_request(ACT_TICK, 0, 0, 0, 1'b0);
      send_request(ACT_READ, 1, 0, 0, 1'b0);

      issued = 0;
      while (issued < REQ_TOTAL) begin
         act   = pick_action();
         idx   = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom)
                                             : INDEX_W'($urandom_range(0, NUM_TIMERS - 1));
         ticks = ($urandom_range(0, 99) < 85) ? TICK_W'($urandom_range(0, 6))
                                              : TICK_W'($urandom);
         reps  = ($urandom_range(0, 9) < 7) ? REP_W'($urandom_range(0, 4))
                                            : REP_W'($urandom);
         if (issued < REQ_TOTAL - CALM_TAIL && $urandom_range(0, 3) == 0)
            idle_burst($urandom_range(1, 3));
         send_request(act, idx, ticks, reps, 1'($urandom));
         if (act <= ACT_READ) issued++;
      end
      start = 1'b0;

      while (timer_sb.pending() != 0) @(posedge clock);
      repeat (NUM_TIMERS + 4) @(posedge clock);

      if (timer_sb.mismatches == 0 && timer_sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
